[sv/mips32r6_integer_alu_top_defines.svh]
// assertion macros for the integer alu
`ifndef MIPS32R6_INTEGER_ALU_TOP_DEFINES_SVH
`define MIPS32R6_INTEGER_ALU_TOP_DEFINES_SVH
`define ALU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alu check failed");
`define ALU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alu check failed");
`endif

[sv/alu_pkg.sv]
// types and constants shared by the integer alu
package alu_pkg;
   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_ADDIU = 6'd1, OP_ADDU = 6'd2, OP_ALIGN = 6'd3, OP_AND = 6'd4,
      OP_ANDI = 6'd5, OP_AUI = 6'd6, OP_BITSWAP = 6'd7, OP_CLO = 6'd8, OP_CLZ = 6'd9,
      OP_DIV = 6'd10, OP_DIVU = 6'd11, OP_EXT = 6'd12, OP_INS = 6'd13, OP_LSA = 6'd14,
      OP_MOD = 6'd15, OP_MODU = 6'd16, OP_MUH = 6'd17, OP_MUHU = 6'd18, OP_MUL = 6'd19,
      OP_MULU = 6'd20, OP_NOR = 6'd21, OP_OR = 6'd22, OP_ORI = 6'd23, OP_ROTR = 6'd24,
      OP_ROTRV = 6'd25, OP_SEB = 6'd26, OP_SEH = 6'd27, OP_SELEQZ = 6'd28,
      OP_SELNEZ = 6'd29, OP_SLL = 6'd30, OP_SLLV = 6'd31, OP_SLT = 6'd32,
      OP_SLTI = 6'd33, OP_SLTIU = 6'd34, OP_SLTU = 6'd35, OP_SRA = 6'd36,
      OP_SRAV = 6'd37, OP_SRL = 6'd38, OP_SRLV = 6'd39, OP_SUB = 6'd40,
      OP_SUBU = 6'd41, OP_TEQ = 6'd42, OP_TGE = 6'd43, OP_TGEU = 6'd44,
      OP_TLT = 6'd45, OP_TLTU = 6'd46, OP_TNE = 6'd47, OP_WSBH = 6'd48,
      OP_XOR = 6'd49, OP_XORI = 6'd50
   } op_type;

   localparam logic [1:0] EXC_NONE = 2'd0;
   localparam logic [1:0] EXC_OVF  = 2'd1;
   localparam logic [1:0] EXC_TRAP = 2'd2;

   typedef enum logic [1:0] {CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2,
      CLS_NONE = 2'd3} cls_type;

   typedef struct packed {
      logic [5:0]  op;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
      logic [15:0] imm16;
      logic [4:0]  shift_amount;
      logic [4:0]  field_msb;
      logic [1:0]  byte_pos;
      logic [4:0]  dest_reg;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write_enable;
      logic [4:0]  dest_out;
      logic [1:0]  exception;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      cls_type     cls;
      logic [31:0] simple_res;
      logic        simple_we;
      logic [1:0]  simple_exc;
   } work_type;
endpackage

[sv/mips32r6_integer_alu_top.sv]
// top level of the mips32r6 integer alu
// usage:
// - req channel carries one decoded instruction per item (req_valid / req_stall)
// - rsp channel returns one result item per instruction, in order
// - simple operations pass the front register, the queue and the result register,
//   and one item per cycle is sustained when nothing stalls
// - multiply: an extra back-end state; no new item is taken until the product is out
// - divide and modulo: computed by the one-bit-per-cycle divider, and the back end
//   holds later items until the divide finishes
// - the front register, a two-entry queue and the result register decouple
//   the channels, so a new item is taken while a result waits on rsp_stall
// - rsp_stall holds the result register steady and backs up the queue,
//   then req_stall rises
// - reset is synchronous and empties all stages; no state survives an item
module mips32r6_integer_alu_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  alu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output alu_pkg::rsp_type rsp_data
);
`include "mips32r6_integer_alu_top_defines.svh"
   logic              fv, fs, bv, bs;
   alu_pkg::work_type fd, bd;

   alu_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .q_valid(fv), .q_stall(fs), .q_data(fd)
   );
   alu_fifo u_fifo (
      .clock(clock), .reset(reset), .in_valid(fv), .in_stall(fs), .in_data(fd),
      .out_valid(bv), .out_stall(bs), .out_data(bd)
   );
   alu_back u_back (
      .clock(clock), .reset(reset), .q_valid(bv), .q_stall(bs), .q_data(bd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   `ALU_ASSERT_IMPL(a_no_we_on_exc, clock, reset,
      rsp_valid && rsp_data.exception != alu_pkg::EXC_NONE, !rsp_data.write_enable)
   `ALU_ASSERT_IMPL(a_no_we_r0, clock, reset,
      rsp_valid && rsp_data.dest_out == 5'd0, !rsp_data.write_enable)
   `ALU_ASSERT_NEXT(a_front_holds, clock, reset, fv && fs, fv)
endmodule

[sv/alu_front.sv]
// front end: accepts items, classifies them and computes simple-operation results
module alu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  alu_pkg::req_type     req_data,
   output logic                 q_valid,
   input  logic                 q_stall,
   output alu_pkg::work_type    q_data
);
   logic                v_ff, v_in;
   alu_pkg::work_type   w_ff, w_in;
   logic [31:0] rs, rt, sx, zx, r;
   logic [4:0]  sa, rsa;
   logic [5:0]  lc;
   logic [31:0] m, ins_m;
   logic [63:0] dbl;
   logic        we, slt_s, slt_u, ovf;
   logic [32:0] sum, dif;
   logic [1:0]  exc;
   alu_pkg::cls_type cls;
   integer i;

   assign rs = req_data.rs_value;
   assign rt = req_data.rt_value;
   assign sa = req_data.shift_amount;
   assign rsa = rs[4:0];
   assign sx = {{16{req_data.imm16[15]}}, req_data.imm16};
   assign zx = {16'd0, req_data.imm16};
   assign slt_s = $signed(rs) < $signed(rt);
   assign slt_u = rs < rt;
   assign sum = {1'b0, rs} + {1'b0, rt};
   assign dif = {1'b0, rs} - {1'b0, rt};

   always_comb begin
      r = 32'd0;
      we = 1'b1;
      exc = alu_pkg::EXC_NONE;
      cls = alu_pkg::CLS_SIMPLE;
      ovf = 1'b0;
      lc = 6'd0;
      m = 32'd0;
      ins_m = 32'd0;
      dbl = 64'd0;
      unique case (req_data.op)
         alu_pkg::OP_ADD: begin
            r = sum[31:0];
            ovf = (rs[31] == rt[31]) && (r[31] != rs[31]);
         end
         alu_pkg::OP_ADDIU: r = rs + sx;
         alu_pkg::OP_ADDU: r = sum[31:0];
         alu_pkg::OP_ALIGN: begin
            dbl = {rt, rs} << {req_data.byte_pos, 3'b000};
            r = (req_data.byte_pos == 2'd0) ? rt : dbl[63:32];
         end
         alu_pkg::OP_AND: r = rs & rt;
         alu_pkg::OP_ANDI: r = rs & zx;
         alu_pkg::OP_AUI: r = rs + {req_data.imm16, 16'd0};
         alu_pkg::OP_BITSWAP:
            for (i = 0; i < 32; i++) r[i] = rt[(i & ~7) + 7 - (i & 7)];
         alu_pkg::OP_CLO, alu_pkg::OP_CLZ: begin
            for (i = 31; i >= 0; i--)
               if ((rs[i] == (req_data.op == alu_pkg::OP_CLZ)) && lc == 6'd0)
                  lc = 6'(32 - i);
            lc = (lc == 6'd0) ? 6'd32 : lc - 6'd1;
            r = {26'd0, lc};
         end
         alu_pkg::OP_DIV, alu_pkg::OP_DIVU, alu_pkg::OP_MOD, alu_pkg::OP_MODU:
            cls = alu_pkg::CLS_DIV;
         alu_pkg::OP_MUH, alu_pkg::OP_MUHU, alu_pkg::OP_MUL, alu_pkg::OP_MULU:
            cls = alu_pkg::CLS_MUL;
         alu_pkg::OP_EXT: begin
            m = (req_data.field_msb == 5'd31) ? 32'hFFFFFFFF :
               ~(32'hFFFFFFFF << (req_data.field_msb + 5'd1));
            r = (rs >> sa) & m;
         end
         alu_pkg::OP_INS: begin
            if (req_data.field_msb < sa) r = rt;
            else begin
               ins_m = (32'hFFFFFFFF >> (5'd31 - (req_data.field_msb - sa))) << sa;
               r = (rt & ~ins_m) | ((rs << sa) & ins_m);
            end
         end
         alu_pkg::OP_LSA: r = (rs << ({3'd0, req_data.byte_pos} + 5'd1)) + rt;
         alu_pkg::OP_NOR: r = ~(rs | rt);
         alu_pkg::OP_OR: r = rs | rt;
         alu_pkg::OP_ORI: r = rs | zx;
         alu_pkg::OP_ROTR: begin
            dbl = {rt, rt} >> sa;
            r = dbl[31:0];
         end
         alu_pkg::OP_ROTRV: begin
            dbl = {rt, rt} >> rsa;
            r = dbl[31:0];
         end
         alu_pkg::OP_SEB: r = {{24{rt[7]}}, rt[7:0]};
         alu_pkg::OP_SEH: r = {{16{rt[15]}}, rt[15:0]};
         alu_pkg::OP_SELEQZ: r = (rt == 32'd0) ? rs : 32'd0;
         alu_pkg::OP_SELNEZ: r = (rt != 32'd0) ? rs : 32'd0;
         alu_pkg::OP_SLL: r = rt << sa;
         alu_pkg::OP_SLLV: r = rt << rsa;
         alu_pkg::OP_SLT: r = {31'd0, slt_s};
         alu_pkg::OP_SLTI: r = {31'd0, $signed(rs) < $signed(sx)};
         alu_pkg::OP_SLTIU: r = {31'd0, rs < sx};
         alu_pkg::OP_SLTU: r = {31'd0, slt_u};
         alu_pkg::OP_SRA: r = 32'($signed(rt) >>> sa);
         alu_pkg::OP_SRAV: r = 32'($signed(rt) >>> rsa);
         alu_pkg::OP_SRL: r = rt >> sa;
         alu_pkg::OP_SRLV: r = rt >> rsa;
         alu_pkg::OP_SUB: begin
            r = dif[31:0];
            ovf = (rs[31] != rt[31]) && (r[31] != rs[31]);
         end
         alu_pkg::OP_SUBU: r = dif[31:0];
         alu_pkg::OP_TEQ, alu_pkg::OP_TGE, alu_pkg::OP_TGEU, alu_pkg::OP_TLT,
         alu_pkg::OP_TLTU, alu_pkg::OP_TNE: begin
            we = 1'b0;
            if ((req_data.op == alu_pkg::OP_TEQ && rs == rt) ||
                (req_data.op == alu_pkg::OP_TNE && rs != rt) ||
                (req_data.op == alu_pkg::OP_TGE && !slt_s) ||
                (req_data.op == alu_pkg::OP_TGEU && !slt_u) ||
                (req_data.op == alu_pkg::OP_TLT && slt_s) ||
                (req_data.op == alu_pkg::OP_TLTU && slt_u))
               exc = alu_pkg::EXC_TRAP;
         end
         alu_pkg::OP_WSBH: r = {rt[23:16], rt[31:24], rt[7:0], rt[15:8]};
         alu_pkg::OP_XOR: r = rs ^ rt;
         alu_pkg::OP_XORI: r = rs ^ zx;
         default: begin
            we = 1'b0;
            cls = alu_pkg::CLS_NONE;
         end
      endcase
      if (ovf) begin
         r = 32'd0;
         we = 1'b0;
         exc = alu_pkg::EXC_OVF;
      end
      if (req_data.dest_reg == 5'd0) we = 1'b0;
   end

   assign req_stall = v_ff && q_stall;

   always_comb begin
      v_in = v_ff && q_stall;
      w_in = w_ff;
      if (!req_stall) begin
         v_in = req_valid;
         w_in.req = req_data;
         w_in.cls = cls;
         w_in.simple_res = r;
         w_in.simple_we = we;
         w_in.simple_exc = exc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
      w_ff <= w_in;
   end

   assign q_valid = v_ff;
   assign q_data = w_ff;
endmodule

[sv/alu_fifo.sv]
// two-entry queue between front and back
module alu_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  alu_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output alu_pkg::work_type out_data
);
   alu_pkg::work_type mem_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign in_stall = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

[sv/alu_div.sv]
// radix-2 divider, one quotient bit per cycle
module alu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};

   always_comb begin
      cnt_in = cnt_ff;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = 6'd32;
         q_in = dividend;
         r_in = 32'd0;
         d_in = divisor;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         done_in = cnt_ff == 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = cnt_ff != 6'd0;
   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

[sv/alu_back.sv]
// back end: multiply, divide and result register
module alu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_stall,
   input  alu_pkg::work_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alu_pkg::rsp_type  rsp_data
);
   typedef enum logic [2:0] {ST_RUN = 3'b001, ST_MUL = 3'b010, ST_DIV = 3'b100} st_type;
   st_type            st_ff, st_in;
   alu_pkg::work_type h_ff, h_in;
   logic [63:0]       p_ff, p_in;
   logic              o_v_ff, o_v_in;
   alu_pkg::rsp_type  o_ff, o_in;
   logic              out_free, take, dstart, dbusy, ddone, neg, sgn;
   logic [31:0]       a, b, dq, dr, hi, mag_a, mag_b, rv;
   logic              dz;

   function automatic logic ddone_seen(input logic d, input alu_pkg::work_type w);
      ddone_seen = d || (w.cls == alu_pkg::CLS_DIV);
   endfunction

   assign out_free = !o_v_ff || !rsp_stall;
   assign q_stall = !(st_ff == ST_RUN && out_free);
   assign take = q_valid && !q_stall;
   assign sgn = q_data.req.op == alu_pkg::OP_DIV || q_data.req.op == alu_pkg::OP_MOD;
   assign mag_a = (sgn && q_data.req.rs_value[31]) ? -q_data.req.rs_value : q_data.req.rs_value;
   assign mag_b = (sgn && q_data.req.rt_value[31]) ? -q_data.req.rt_value : q_data.req.rt_value;
   assign dstart = take && q_data.cls == alu_pkg::CLS_DIV;
   assign a = h_ff.req.rs_value;
   assign b = h_ff.req.rt_value;

   alu_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(mag_a), .divisor(mag_b),
      .busy(dbusy), .done(ddone), .quotient(dq), .remainder(dr)
   );

   always_comb begin
      st_in = st_ff;
      h_in = h_ff;
      p_in = p_ff;
      o_v_in = o_v_ff && rsp_stall;
      o_in = o_ff;
      hi = p_ff[63:32];
      neg = 1'b0;
      rv = 32'd0;
      dz = b == 32'd0;
      unique case (st_ff)
         ST_RUN: begin
            if (take) begin
               h_in = q_data;
               if (q_data.cls == alu_pkg::CLS_MUL) begin
                  p_in = q_data.req.rs_value * q_data.req.rt_value;
                  st_in = ST_MUL;
               end else if (q_data.cls == alu_pkg::CLS_DIV) begin
                  st_in = ST_DIV;
               end else begin
                  o_v_in = 1'b1;
                  o_in.result = q_data.simple_res;
                  o_in.write_enable = q_data.simple_we;
                  o_in.dest_out = q_data.req.dest_reg;
                  o_in.exception = q_data.simple_exc;
               end
            end
         end
         ST_MUL: begin
            if (out_free) begin
               if (h_ff.req.op == alu_pkg::OP_MUH)
                  hi = p_ff[63:32] - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
               if (h_ff.req.op == alu_pkg::OP_MUL || h_ff.req.op == alu_pkg::OP_MULU)
                  rv = p_ff[31:0];
               else rv = hi;
               o_v_in = 1'b1;
               o_in.result = rv;
               o_in.write_enable = h_ff.req.dest_reg != 5'd0;
               o_in.dest_out = h_ff.req.dest_reg;
               o_in.exception = alu_pkg::EXC_NONE;
               st_in = ST_RUN;
            end
         end
         ST_DIV: begin
            if (!dbusy && out_free && !dstart && ddone_seen(ddone, h_ff)) begin
               if (h_ff.req.op == alu_pkg::OP_DIV) begin
                  neg = a[31] ^ b[31];
                  rv = neg ? -dq : dq;
               end else if (h_ff.req.op == alu_pkg::OP_MOD) rv = a[31] ? -dr : dr;
               else if (h_ff.req.op == alu_pkg::OP_DIVU) rv = dq;
               else rv = dr;
               o_v_in = 1'b1;
               o_in.result = dz ? 32'd0 : rv;
               o_in.write_enable = !dz && h_ff.req.dest_reg != 5'd0;
               o_in.dest_out = h_ff.req.dest_reg;
               o_in.exception = alu_pkg::EXC_NONE;
               st_in = ST_RUN;
            end
         end
         default: st_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RUN;
         o_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         o_v_ff <= o_v_in;
      end
      h_ff <= h_in;
      p_ff <= p_in;
      o_ff <= o_in;
   end

   assign rsp_valid = o_v_ff;
   assign rsp_data = o_ff;
endmodule
